@@ src/hurp_pkg.sv @@
// Shared types, constants and helpers of the HTTP upload request parser.
package hurp_pkg;

  localparam int LINE_LEN     = 1024;
  localparam int NAME_LEN     = 128;
  localparam int FRAGMENT_MAX = 500;
  localparam int FIFO_DEPTH   = 4;

  localparam int FILL_W     = $clog2(LINE_LEN);
  localparam int FRAG_W     = $clog2(FRAGMENT_MAX + 1);
  localparam int NAME_LIMIT = (NAME_LEN < 255) ? NAME_LEN : 255;
  localparam int LEN_POS    = 16;
  localparam int METHOD_MIN = 14;
  localparam int KEY_LEN    = 10;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam int PAT_W = 24 * 8;
  localparam int NPAT  = 9;

  localparam int PI_GET  = 0;
  localparam int PI_POST = 1;
  localparam int PI_UPL  = 2;
  localparam int PI_ROOT = 3;
  localparam int PI_CL   = 4;
  localparam int PI_CT   = 5;
  localparam int PI_MP   = 6;
  localparam int PI_AO   = 7;
  localparam int PI_CD   = 8;

  localparam logic [PAT_W-1:0] PAT_STR [NPAT] = '{
    PAT_W'("GET"),
    PAT_W'("POST"),
    PAT_W'("/upload?X-Filename"),
    PAT_W'("/ "),
    PAT_W'("Content-Length:"),
    PAT_W'("Content-Type:"),
    PAT_W'("multipart/form-data"),
    PAT_W'("application/octet-stream"),
    PAT_W'("Content-Disposition:")
  };
  localparam int PAT_LEN [NPAT] = '{3, 4, 18, 2, 15, 13, 19, 24, 20};
  localparam int PAT_OFF [NPAT] = '{0, 0, 5, 4, 0, 0, 14, 14, 0};

  localparam logic [8*KEY_LEN-1:0] NAME_KEY = "filename=\"";

  localparam int PF_POST   = 0;
  localparam int PF_SUBMIT = 1;
  localparam int PF_BODY   = 2;
  localparam int PF_FILE   = 3;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_HEADER  = 3'd1,
    PH_DONE    = 3'd2,
    PH_CONTENT = 3'd3,
    PH_FILE    = 3'd4,
    PH_FAIL    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    RK_NONE   = 2'd0,
    RK_ROOT   = 2'd1,
    RK_UPLOAD = 2'd2
  } rkind_t;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_BYTE  = 3'd1,
    KIND_ROOT  = 3'd2,
    KIND_OK    = 3'd3,
    KIND_BAD   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    V_NONE = 2'd0,
    V_ROOT = 2'd1,
    V_OK   = 2'd2,
    V_BAD  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    LP_WS   = 2'd0,
    LP_DIG  = 2'd1,
    LP_STOP = 2'd2
  } lparse_t;

  typedef struct packed {
    logic        has_start;
    logic        has_byte;
    verdict_t    verdict;
    logic [7:0]  data;
    logic [30:0] part;
    logic        fend;
    logic        fin;
    logic [31:0] size;
    logic [7:0]  nlen;
  } cmd_t;

  function automatic logic pat_ok(input int idx, input logic [FILL_W-1:0] pos,
                                  input logic [7:0] b);
    int rel;
    rel = int'(pos) - PAT_OFF[idx];
    if (rel < 0 || rel >= PAT_LEN[idx]) return 1'b1;
    return b == PAT_STR[idx][8*(PAT_LEN[idx]-1-rel) +: 8];
  endfunction

  function automatic logic [FILL_W-1:0] pat_end(input int idx);
    return FILL_W'(PAT_OFF[idx] + PAT_LEN[idx]);
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] k);
    return NAME_KEY[8*(KEY_LEN-1-int'(k)) +: 8];
  endfunction

endpackage

@@ src/hurp_if.sv @@
// Request and result channel interfaces of the HTTP upload request parser.
interface hurp_in_if;
  logic       valid;
  logic       ready;
  logic       conn_start;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, conn_start, data_byte, packet_end, input ready);
  modport sink   (input valid, conn_start, data_byte, packet_end, output ready);
endinterface

interface hurp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [30:0] part_index;
  logic        fragment_end;
  logic        final_fragment;
  logic [31:0] body_size;
  logic [7:0]  name_length;
  logic        last;

  modport source (output valid, out_kind, out_byte, part_index, fragment_end,
                  final_fragment, body_size, name_length, last, input ready);
  modport sink   (input valid, out_kind, out_byte, part_index, fragment_end,
                  final_fragment, body_size, name_length, last, output ready);
endinterface

@@ src/http_upload_request_parser.sv @@
// Top level of the HTTP upload request parser.
// Input channel in_ch carries one received TCP byte per request, with
// conn_start (clear parse state before this byte) and packet_end.
// Output channel out_ch carries result requests: file start, file byte,
// root page, upload ok or bad request; last marks the final result of a byte.
// The front end takes one byte per cycle while the queue has room and
// updates all line matchers, the length parser and the name search on the
// fly, so a CR judges its line in the same cycle. It queues a command per
// byte that has results in a four-entry queue; bytes without results queue
// nothing. The back end issues one result per cycle from that command
// while out_ch is not stalled, and pops the next command only after all
// results of the current one (1 to 3 per byte) are issued.
// A byte's first result passes the queue, the command register and the
// output register. A stalled receiver fills the output register, the
// command register and then the queue, after which in_ch.ready drops.
// A synchronous active-low reset clears the parse state, empties the queue
// and drops out_ch.valid; no clearing pass is needed.
module http_upload_request_parser (
  input  logic       clk,
  input  logic       rst_n,
  hurp_in_if.sink    in_ch,
  hurp_out_if.source out_ch
);

  logic           q_push, q_full, q_pop, q_empty;
  hurp_pkg::cmd_t q_data, q_head;

  hurp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  hurp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  hurp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ src/hurp_front.sv @@
// Front end: accepts request bytes, tracks line matches and parse state, emits commands.
module hurp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  hurp_in_if.sink               in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output hurp_pkg::cmd_t        q_data
);

  hurp_pkg::phase_t               phase_r, phase_nxt, e_phase;
  hurp_pkg::rkind_t               rk_r, rk_nxt, e_rk;
  logic [3:0]                     pf_r, pf_nxt, e_pf;
  logic [hurp_pkg::FILL_W-1:0]    fill_r, fill_nxt, e_fill;
  logic [7:0]                     fnl_r, fnl_nxt, e_fnl;
  logic [31:0]                    ds_r, ds_nxt, e_ds;
  logic [31:0]                    bc_r, bc_nxt, e_bc;
  logic [30:0]                    fn_r, fn_nxt, e_fn;
  logic [hurp_pkg::FRAG_W-1:0]    ff_r, ff_nxt, e_ff;

  logic [hurp_pkg::NPAT-1:0]      pm_r, pm_nxt, pm_cur, pdone;
  logic                           sp_r, sp_nxt, sp_cur;
  hurp_pkg::lparse_t              lst_r, lst_nxt, lst_cur;
  logic                           lneg_r, lneg_nxt, lneg_cur;
  logic [31:0]                    lval_r, lval_nxt, lval_cur, lparsed;
  logic [3:0]                     kidx_r, kidx_nxt, kidx_cur;
  logic                           nfnd_r, nfnd_nxt, nfnd_cur;
  logic                           nzero_r, nzero_nxt, nzero_cur;
  logic                           nquo_r, nquo_nxt, nquo_cur;
  logic [7:0]                     ncnt_r, ncnt_nxt, ncnt_cur;

  logic                           accept, line_new, is_ws, is_dig, fend;
  logic [7:0]                     b;
  logic [31:0]                    dig;
  hurp_pkg::cmd_t                 cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign is_ws       = (b == hurp_pkg::CH_SP) || (b >= 8'd9 && b <= 8'd13);
  assign is_dig      = (b >= 8'h30) && (b <= 8'h39);
  assign dig         = {24'd0, b - 8'h30};

  always_comb begin
    e_phase = in_ch.conn_start ? hurp_pkg::PH_METHOD : phase_r;
    e_rk    = in_ch.conn_start ? hurp_pkg::RK_NONE : rk_r;
    e_pf    = in_ch.conn_start ? 4'd0 : pf_r;
    e_fill  = in_ch.conn_start ? '0 : fill_r;
    e_fnl   = in_ch.conn_start ? 8'd0 : fnl_r;
    e_ds    = in_ch.conn_start ? 32'd0 : ds_r;
    e_bc    = in_ch.conn_start ? 32'd0 : bc_r;
    e_fn    = in_ch.conn_start ? 31'd0 : fn_r;
    e_ff    = in_ch.conn_start ? '0 : ff_r;

    line_new  = (e_fill == '0);
    pm_cur    = line_new ? '1 : pm_r;
    sp_cur    = line_new ? 1'b0 : sp_r;
    lst_cur   = line_new ? hurp_pkg::LP_WS : lst_r;
    lneg_cur  = line_new ? 1'b0 : lneg_r;
    lval_cur  = line_new ? 32'd0 : lval_r;
    kidx_cur  = line_new ? 4'd0 : kidx_r;
    nfnd_cur  = line_new ? 1'b0 : nfnd_r;
    nzero_cur = line_new ? 1'b0 : nzero_r;
    nquo_cur  = line_new ? 1'b0 : nquo_r;
    ncnt_cur  = line_new ? 8'd0 : ncnt_r;

    for (int i = 0; i < hurp_pkg::NPAT; i++) begin
      pdone[i] = pm_cur[i] && (e_fill >= hurp_pkg::pat_end(i));
    end
    lparsed = lneg_cur ? (32'd0 - lval_cur) : lval_cur;

    phase_nxt = e_phase;
    rk_nxt    = e_rk;
    pf_nxt    = e_pf;
    fill_nxt  = e_fill;
    fnl_nxt   = e_fnl;
    ds_nxt    = e_ds;
    bc_nxt    = e_bc;
    fn_nxt    = e_fn;
    ff_nxt    = e_ff;
    pm_nxt    = pm_cur;
    sp_nxt    = sp_cur;
    lst_nxt   = lst_cur;
    lneg_nxt  = lneg_cur;
    lval_nxt  = lval_cur;
    kidx_nxt  = kidx_cur;
    nfnd_nxt  = nfnd_cur;
    nzero_nxt = nzero_cur;
    nquo_nxt  = nquo_cur;
    ncnt_nxt  = ncnt_cur;
    fend      = 1'b0;
    cmd       = '0;

    if (e_phase == hurp_pkg::PH_FILE) begin
      bc_nxt = e_bc + 32'd1;
      if (e_pf[hurp_pkg::PF_FILE] || b != hurp_pkg::CH_LF) begin
        cmd.has_start = !e_pf[hurp_pkg::PF_FILE];
        cmd.size      = e_ds;
        cmd.nlen      = e_fnl;
        pf_nxt[hurp_pkg::PF_FILE] = 1'b1;
        ff_nxt = e_ff + 1'b1;
        fend   = in_ch.packet_end || (ff_nxt >= hurp_pkg::FRAG_W'(hurp_pkg::FRAGMENT_MAX));
        cmd.has_byte = 1'b1;
        cmd.data     = b;
        cmd.part     = e_fn;
        cmd.fend     = fend;
        cmd.fin      = fend && (bc_nxt == e_ds);
        if (fend) begin
          fn_nxt = e_fn + 31'd1;
          ff_nxt = '0;
        end
      end
    end else begin
      if (e_pf[hurp_pkg::PF_BODY]) bc_nxt = e_bc + 32'd1;
      if (!(line_new && b == hurp_pkg::CH_LF)) begin
        if (e_phase == hurp_pkg::PH_CONTENT && !e_pf[hurp_pkg::PF_BODY]) begin
          bc_nxt = 32'd1;
          pf_nxt[hurp_pkg::PF_BODY] = 1'b1;
        end
        if (b == hurp_pkg::CH_CR) begin
          unique case (e_phase)
            hurp_pkg::PH_METHOD: begin
              if (e_fill < hurp_pkg::FILL_W'(hurp_pkg::METHOD_MIN)) begin
                phase_nxt = hurp_pkg::PH_FAIL;
              end else if (pdone[hurp_pkg::PI_GET]) begin
                if (pdone[hurp_pkg::PI_ROOT]) begin
                  rk_nxt    = hurp_pkg::RK_ROOT;
                  phase_nxt = hurp_pkg::PH_HEADER;
                end else begin
                  phase_nxt = hurp_pkg::PH_FAIL;
                end
              end else if (pdone[hurp_pkg::PI_POST]) begin
                pf_nxt[hurp_pkg::PF_POST] = 1'b1;
                if (sp_cur && pdone[hurp_pkg::PI_UPL]) begin
                  rk_nxt    = hurp_pkg::RK_UPLOAD;
                  phase_nxt = hurp_pkg::PH_HEADER;
                end else begin
                  phase_nxt = hurp_pkg::PH_FAIL;
                end
              end else begin
                phase_nxt = hurp_pkg::PH_FAIL;
              end
            end
            hurp_pkg::PH_HEADER: begin
              if (line_new) begin
                phase_nxt = e_pf[hurp_pkg::PF_POST] ? hurp_pkg::PH_CONTENT : hurp_pkg::PH_DONE;
              end else if (e_pf[hurp_pkg::PF_POST]) begin
                if (pdone[hurp_pkg::PI_CL]) begin
                  ds_nxt = lparsed;
                end else if (pdone[hurp_pkg::PI_CT]) begin
                  if (pdone[hurp_pkg::PI_MP] || pdone[hurp_pkg::PI_AO]) begin
                    pf_nxt[hurp_pkg::PF_SUBMIT] = 1'b1;
                  end else begin
                    phase_nxt = hurp_pkg::PH_FAIL;
                  end
                end
              end
            end
            hurp_pkg::PH_CONTENT: begin
              if (line_new) begin
                phase_nxt = (e_ds != 32'd0 && e_fnl != 8'd0) ? hurp_pkg::PH_FILE
                                                             : hurp_pkg::PH_FAIL;
              end else if (pdone[hurp_pkg::PI_CD] && nfnd_cur) begin
                fnl_nxt = ncnt_cur;
              end
            end
            default: begin
            end
          endcase
          fill_nxt = '0;
        end else begin
          fill_nxt = e_fill + 1'b1;
          for (int i = 0; i < hurp_pkg::NPAT; i++) begin
            pm_nxt[i] = pm_cur[i] && hurp_pkg::pat_ok(i, e_fill, b);
          end
          if (e_fill >= hurp_pkg::FILL_W'(5) && b == hurp_pkg::CH_SP) sp_nxt = 1'b1;
          if (e_fill >= hurp_pkg::FILL_W'(hurp_pkg::LEN_POS)) begin
            unique case (lst_cur)
              hurp_pkg::LP_WS: begin
                if (is_ws) begin
                  lst_nxt = hurp_pkg::LP_WS;
                end else if (b == hurp_pkg::CH_PLUS || b == hurp_pkg::CH_MINUS) begin
                  lneg_nxt = (b == hurp_pkg::CH_MINUS);
                  lst_nxt  = hurp_pkg::LP_DIG;
                end else if (is_dig) begin
                  lval_nxt = dig;
                  lst_nxt  = hurp_pkg::LP_DIG;
                end else begin
                  lst_nxt = hurp_pkg::LP_STOP;
                end
              end
              hurp_pkg::LP_DIG: begin
                if (is_dig) begin
                  lval_nxt = (lval_cur << 3) + (lval_cur << 1) + dig;
                end else begin
                  lst_nxt = hurp_pkg::LP_STOP;
                end
              end
              default: begin
                lst_nxt = hurp_pkg::LP_STOP;
              end
            endcase
          end
          if (!nzero_cur) begin
            if (b == 8'd0) begin
              nzero_nxt = 1'b1;
            end else if (!nfnd_cur) begin
              if (b == hurp_pkg::key_char(kidx_cur)) begin
                kidx_nxt = kidx_cur + 4'd1;
                if (kidx_cur == 4'(hurp_pkg::KEY_LEN - 1)) nfnd_nxt = 1'b1;
              end else begin
                kidx_nxt = (b == hurp_pkg::CH_F) ? 4'd1 : 4'd0;
              end
            end else if (!nquo_cur) begin
              if (b == hurp_pkg::CH_QUOTE) begin
                nquo_nxt = 1'b1;
              end else if (ncnt_cur < 8'(hurp_pkg::NAME_LIMIT)) begin
                ncnt_nxt = ncnt_cur + 8'd1;
              end
            end
          end
          if (fill_nxt >= hurp_pkg::FILL_W'(hurp_pkg::LINE_LEN - 1)) begin
            phase_nxt = hurp_pkg::PH_FAIL;
            fill_nxt  = '0;
          end
        end
      end
    end

    if (in_ch.packet_end) begin
      ff_nxt = '0;
      if (phase_nxt == hurp_pkg::PH_FILE && bc_nxt == ds_nxt) phase_nxt = hurp_pkg::PH_DONE;
      priority if (phase_nxt == hurp_pkg::PH_FAIL) begin
        cmd.verdict = hurp_pkg::V_BAD;
      end else if (phase_nxt == hurp_pkg::PH_DONE && rk_nxt == hurp_pkg::RK_ROOT) begin
        cmd.verdict = hurp_pkg::V_ROOT;
      end else if (phase_nxt == hurp_pkg::PH_DONE && rk_nxt == hurp_pkg::RK_UPLOAD) begin
        cmd.verdict = hurp_pkg::V_OK;
      end else begin
        cmd.verdict = hurp_pkg::V_NONE;
      end
    end
  end

  assign q_data = cmd;
  assign q_push = accept && (cmd.has_start || cmd.has_byte || cmd.verdict != hurp_pkg::V_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hurp_pkg::PH_METHOD;
      rk_r    <= hurp_pkg::RK_NONE;
      pf_r    <= 4'd0;
      fill_r  <= '0;
      fnl_r   <= 8'd0;
      ds_r    <= 32'd0;
      bc_r    <= 32'd0;
      fn_r    <= 31'd0;
      ff_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      rk_r    <= rk_nxt;
      pf_r    <= pf_nxt;
      fill_r  <= fill_nxt;
      fnl_r   <= fnl_nxt;
      ds_r    <= ds_nxt;
      bc_r    <= bc_nxt;
      fn_r    <= fn_nxt;
      ff_r    <= ff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pm_r    <= pm_nxt;
      sp_r    <= sp_nxt;
      lst_r   <= lst_nxt;
      lneg_r  <= lneg_nxt;
      lval_r  <= lval_nxt;
      kidx_r  <= kidx_nxt;
      nfnd_r  <= nfnd_nxt;
      nzero_r <= nzero_nxt;
      nquo_r  <= nquo_nxt;
      ncnt_r  <= ncnt_nxt;
    end
  end

endmodule

@@ src/hurp_fifo.sv @@
// Short command queue between the front and back ends.
module hurp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hurp_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output hurp_pkg::cmd_t head,
  output logic           empty
);

  localparam int PTR_W = $clog2(hurp_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(hurp_pkg::FIFO_DEPTH + 1);

  hurp_pkg::cmd_t   mem_r [hurp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(hurp_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_W'(hurp_pkg::FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PTR_W'(hurp_pkg::FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

@@ src/hurp_back.sv @@
// Back end: expands queued commands into result requests on the output register.
module hurp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  hurp_pkg::cmd_t q_head,
  output logic           q_pop,
  hurp_out_if.source     out_ch
);

  hurp_pkg::cmd_t cur_r, cur_nxt;
  logic           cur_valid_r, cur_valid_nxt;
  logic [2:0]     msk_r, msk_nxt;
  logic           ov_r, ov_nxt;
  logic [2:0]     kind_r, kind_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic [30:0]    part_r, part_nxt;
  logic           fend_r, fend_nxt;
  logic           fin_r, fin_nxt;
  logic [31:0]    size_r, size_nxt;
  logic [7:0]     nlen_r, nlen_nxt;
  logic           last_r, last_nxt;
  logic           load_out;

  assign load_out = !ov_r || out_ch.ready;
  assign q_pop    = !cur_valid_r && !q_empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    msk_nxt       = msk_r;
    ov_nxt        = ov_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    part_nxt      = part_r;
    fend_nxt      = fend_r;
    fin_nxt       = fin_r;
    size_nxt      = size_r;
    nlen_nxt      = nlen_r;
    last_nxt      = last_r;

    if (load_out) begin
      ov_nxt = cur_valid_r;
      if (cur_valid_r) begin
        byte_nxt = 8'd0;
        part_nxt = 31'd0;
        fend_nxt = 1'b0;
        fin_nxt  = 1'b0;
        size_nxt = 32'd0;
        nlen_nxt = 8'd0;
        priority if (msk_r[0]) begin
          kind_nxt   = hurp_pkg::KIND_START;
          size_nxt   = cur_r.size;
          nlen_nxt   = cur_r.nlen;
          msk_nxt[0] = 1'b0;
        end else if (msk_r[1]) begin
          kind_nxt   = hurp_pkg::KIND_BYTE;
          byte_nxt   = cur_r.data;
          part_nxt   = cur_r.part;
          fend_nxt   = cur_r.fend;
          fin_nxt    = cur_r.fin;
          msk_nxt[1] = 1'b0;
        end else begin
          unique case (cur_r.verdict)
            hurp_pkg::V_ROOT: kind_nxt = hurp_pkg::KIND_ROOT;
            hurp_pkg::V_OK:   kind_nxt = hurp_pkg::KIND_OK;
            default:          kind_nxt = hurp_pkg::KIND_BAD;
          endcase
          msk_nxt[2] = 1'b0;
        end
        last_nxt = (msk_nxt == 3'd0);
        if (msk_nxt == 3'd0) cur_valid_nxt = 1'b0;
      end
    end

    if (q_pop) begin
      cur_nxt       = q_head;
      cur_valid_nxt = 1'b1;
      msk_nxt       = {q_head.verdict != hurp_pkg::V_NONE, q_head.has_byte, q_head.has_start};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      ov_r        <= 1'b0;
      msk_r       <= 3'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      ov_r        <= ov_nxt;
      msk_r       <= msk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    part_r <= part_nxt;
    fend_r <= fend_nxt;
    fin_r  <= fin_nxt;
    size_r <= size_nxt;
    nlen_r <= nlen_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.out_kind       = kind_r;
  assign out_ch.out_byte       = byte_r;
  assign out_ch.part_index     = part_r;
  assign out_ch.fragment_end   = fend_r;
  assign out_ch.final_fragment = fin_r;
  assign out_ch.body_size      = size_r;
  assign out_ch.name_length    = nlen_r;
  assign out_ch.last           = last_r;

endmodule

@@ src/hurp_checker.sv @@
// Port-level checks of the HTTP upload request parser and their binding.
module hurp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic       fragment_end,
  input logic       final_fragment,
  input logic       last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(last))
    else $error("stalled result request dropped or changed");

  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == hurp_pkg::KIND_START |-> !last && !fragment_end)
    else $error("file start must be followed by a file byte");

  a_final_in_frag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && final_fragment |-> fragment_end && out_kind == hurp_pkg::KIND_BYTE)
    else $error("final flag outside a fragment end");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == hurp_pkg::KIND_ROOT || out_kind == hurp_pkg::KIND_OK ||
                  out_kind == hurp_pkg::KIND_BAD) |-> last)
    else $error("verdict not last result of its byte");

endmodule

bind http_upload_request_parser hurp_checker u_hurp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.out_kind),
  .fragment_end   (out_ch.fragment_end),
  .final_fragment (out_ch.final_fragment),
  .last           (out_ch.last)
);

@@ test/tb_http_upload_request_parser.sv @@
// Testbench for the HTTP upload request parser: directed request streams
// checked against a behavioral predictor.
`timescale 1ns / 1ps

module tb_http_upload_request_parser;

  typedef struct {
    hurp_pkg::kind_t kind;
    logic [7:0]      data;
    logic [30:0]     part;
    logic            fend;
    logic            fin;
    logic [31:0]     size;
    logic [7:0]      nlen;
    logic            last;
  } result_t;

  typedef logic [7:0] stream_t[$];

  logic clk;
  logic rst_n;
  hurp_in_if  in_ch();
  hurp_out_if out_ch();

  http_upload_request_parser u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  int src_idle;
  int snk_idle;
  int hold_left;
  int err_count;
  result_t pending_results[$];

  // parser state
  hurp_pkg::phase_t ph;
  hurp_pkg::rkind_t rk;
  logic [3:0]       pf;
  logic [7:0]       line_buf[hurp_pkg::LINE_LEN];
  int               fill;
  int               fname_len;
  logic [31:0]      decl_size;
  logic [31:0]      body_cnt;
  logic [30:0]      frag_no;
  int               frag_fill;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_parser();
    ph = hurp_pkg::PH_METHOD;
    rk = hurp_pkg::RK_NONE;
    pf = '0;
    fill = 0;
    fname_len = 0;
    decl_size = '0;
    body_cnt = '0;
    frag_no = '0;
    frag_fill = 0;
  endfunction

  function automatic bit line_has(int pos, string pat);
    for (int k = 0; k < pat.len(); k++) begin
      if (pos + k >= fill || line_buf[pos + k] != pat[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] length_value(int pos);
    logic [31:0] v;
    bit neg;
    v = '0;
    neg = 1'b0;
    while (pos < fill && (line_buf[pos] == " " || (line_buf[pos] >= 9 && line_buf[pos] <= 13)))
      pos++;
    if (pos < fill && (line_buf[pos] == "+" || line_buf[pos] == "-")) begin
      neg = line_buf[pos] == "-";
      pos++;
    end
    while (pos < fill && line_buf[pos] >= "0" && line_buf[pos] <= "9") begin
      v = v * 10 + (line_buf[pos] - "0");
      pos++;
    end
    return neg ? -v : v;
  endfunction

  function automatic void capture_name();
    int eff;
    int p;
    int n;
    int j;
    eff = 0;
    n = 0;
    while (eff < fill && line_buf[eff] != 0) eff++;
    for (p = 0; p + 10 <= eff; p++) begin
      if (line_has(p, "filename=\"")) break;
    end
    if (p + 10 > eff) return;
    for (j = p + 10; j < eff && line_buf[j] != hurp_pkg::CH_QUOTE && n < hurp_pkg::NAME_LIMIT;
         j++) begin
      n++;
    end
    fname_len = n;
  endfunction

  function automatic void judge_line();
    int from;
    int i;
    unique case (ph)
      hurp_pkg::PH_METHOD: begin
        if (fill < hurp_pkg::METHOD_MIN) begin
          ph = hurp_pkg::PH_FAIL;
          return;
        end
        if (line_has(0, "GET")) begin
          from = 4;
        end else if (line_has(0, "POST")) begin
          pf[hurp_pkg::PF_POST] = 1'b1;
          from = 5;
        end else begin
          ph = hurp_pkg::PH_FAIL;
          return;
        end
        i = from;
        while (i < fill && line_buf[i] != hurp_pkg::CH_SP) i++;
        if (i == fill) begin
          ph = hurp_pkg::PH_FAIL;
          return;
        end
        if (i - from == 1 && line_buf[from] == "/" && !pf[hurp_pkg::PF_POST]) begin
          rk = hurp_pkg::RK_ROOT;
        end else if (pf[hurp_pkg::PF_POST] && line_has(from, "/upload?X-Filename")) begin
          rk = hurp_pkg::RK_UPLOAD;
        end else begin
          ph = hurp_pkg::PH_FAIL;
          return;
        end
        ph = hurp_pkg::PH_HEADER;
      end
      hurp_pkg::PH_HEADER: begin
        if (fill == 0) begin
          ph = pf[hurp_pkg::PF_POST] ? hurp_pkg::PH_CONTENT : hurp_pkg::PH_DONE;
        end else if (pf[hurp_pkg::PF_POST]) begin
          if (line_has(0, "Content-Length:")) begin
            decl_size = length_value(hurp_pkg::LEN_POS);
          end else if (line_has(0, "Content-Type:")) begin
            if (line_has(14, "multipart/form-data") || line_has(14, "application/octet-stream"))
              pf[hurp_pkg::PF_SUBMIT] = 1'b1;
            else
              ph = hurp_pkg::PH_FAIL;
          end
        end
      end
      hurp_pkg::PH_CONTENT: begin
        if (fill == 0) begin
          ph = (decl_size > 0 && fname_len != 0) ? hurp_pkg::PH_FILE : hurp_pkg::PH_FAIL;
        end else if (line_has(0, "Content-Disposition:")) begin
          capture_name();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_result(hurp_pkg::kind_t kind, logic [7:0] data,
                                     logic [30:0] part, logic fend, logic fin,
                                     logic [31:0] size, logic [7:0] nlen);
    result_t r;
    r = '{kind, data, part, fend, fin, size, nlen, 1'b0};
    pending_results.push_back(r);
  endfunction

  function automatic void predict_byte(logic cs, logic [7:0] b, logic pe);
    int before_n;
    bit fend;
    before_n = pending_results.size();
    if (cs) clear_parser();
    if (ph == hurp_pkg::PH_FILE) begin
      body_cnt++;
      if (pf[hurp_pkg::PF_FILE] || b != hurp_pkg::CH_LF) begin
        if (!pf[hurp_pkg::PF_FILE]) begin
          pf[hurp_pkg::PF_FILE] = 1'b1;
          add_result(hurp_pkg::KIND_START, '0, '0, 1'b0, 1'b0, decl_size, 8'(fname_len));
        end
        frag_fill++;
        fend = pe || frag_fill >= hurp_pkg::FRAGMENT_MAX;
        add_result(hurp_pkg::KIND_BYTE, b, frag_no, fend, fend && body_cnt == decl_size,
                   '0, '0);
        if (fend) begin
          frag_no++;
          frag_fill = 0;
        end
      end
    end else begin
      if (pf[hurp_pkg::PF_BODY]) body_cnt++;
      if (!(fill == 0 && b == hurp_pkg::CH_LF)) begin
        if (ph == hurp_pkg::PH_CONTENT && !pf[hurp_pkg::PF_BODY]) begin
          body_cnt = 1;
          pf[hurp_pkg::PF_BODY] = 1'b1;
        end
        if (b == hurp_pkg::CH_CR) begin
          judge_line();
          fill = 0;
        end else if (fill < hurp_pkg::LINE_LEN) begin
          line_buf[fill] = b;
          fill++;
        end
        if (fill >= hurp_pkg::LINE_LEN - 1) begin
          ph = hurp_pkg::PH_FAIL;
          fill = 0;
        end
      end
    end
    if (pe) begin
      frag_fill = 0;
      if (ph == hurp_pkg::PH_FILE && body_cnt == decl_size) ph = hurp_pkg::PH_DONE;
      if (ph == hurp_pkg::PH_FAIL)
        add_result(hurp_pkg::KIND_BAD, '0, '0, 1'b0, 1'b0, '0, '0);
      else if (ph == hurp_pkg::PH_DONE && rk == hurp_pkg::RK_ROOT)
        add_result(hurp_pkg::KIND_ROOT, '0, '0, 1'b0, 1'b0, '0, '0);
      else if (ph == hurp_pkg::PH_DONE && rk == hurp_pkg::RK_UPLOAD)
        add_result(hurp_pkg::KIND_OK, '0, '0, 1'b0, 1'b0, '0, '0);
    end
    if (pending_results.size() > before_n)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= $urandom_range(99) >= snk_idle;
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", out_ch.out_kind, -1);
      end else begin
        w = pending_results.pop_front();
        if (out_ch.out_kind != w.kind) report_mismatch("out_kind", out_ch.out_kind, w.kind);
        if (out_ch.out_byte != w.data) report_mismatch("out_byte", out_ch.out_byte, w.data);
        if (out_ch.part_index != w.part)
          report_mismatch("part_index", out_ch.part_index, w.part);
        if (out_ch.fragment_end != w.fend)
          report_mismatch("fragment_end", out_ch.fragment_end, w.fend);
        if (out_ch.final_fragment != w.fin)
          report_mismatch("final_fragment", out_ch.final_fragment, w.fin);
        if (out_ch.body_size != w.size) report_mismatch("body_size", out_ch.body_size, w.size);
        if (out_ch.name_length != w.nlen)
          report_mismatch("name_length", out_ch.name_length, w.nlen);
        if (out_ch.last != w.last) report_mismatch("last", out_ch.last, w.last);
      end
    end
  end

  task automatic send_byte(logic cs, logic [7:0] b, logic pe);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.conn_start <= cs;
    in_ch.data_byte  <= b;
    in_ch.packet_end <= pe;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(cs, b, pe);
  endtask

  // send a stream as one connection; packet end on the last byte and at random
  task automatic send_stream(stream_t s, int pe_pct);
    for (int i = 0; i < s.size(); i++)
      send_byte(i == 0, s[i], i == s.size() - 1 || $urandom_range(99) < pe_pct);
  endtask

  function automatic void put_str(ref stream_t s, input string t);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
  endfunction

  function automatic stream_t upload_stream(string name, int file_bytes, string ctype);
    stream_t s;
    stream_t body;
    put_str(body, "Content-Disposition: x; filename=\"");
    put_str(body, name);
    put_str(body, "\"\r\n\r\n");
    for (int i = 0; i < file_bytes; i++) body.push_back(8'($urandom_range(255)));
    put_str(s, "POST /upload?X-Filename HTTP/1.1\r\nContent-Type: ");
    put_str(s, ctype);
    put_str(s, $sformatf("\r\nContent-Length: %0d\r\n\r\n", body.size()));
    return {s, body};
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_root_page();
    stream_t s;
    put_str(s, "GET / HTTP/1.1\r\nHost: a\r\n\r\n");
    send_stream(s, 0);
    s = {};
    put_str(s, "\nGET /x HTTP/1.1\r\n\r\n");
    send_stream(s, 0);
  endtask

  task automatic test_bad_requests();
    stream_t s;
    put_str(s, "PUT / HTTP/1.1\r\n");
    send_stream(s, 0);
    s = {};
    put_str(s, "GET /\r\n");
    send_stream(s, 0);
    s = {};
    put_str(s, "GET /abcdefghijklm\r\n");
    send_stream(s, 0);
    s = {};
    put_str(s, "POST /upload?X-Filename HTTP/1.1\r\nContent-Type: text/plain\r\n\r\n");
    send_stream(s, 0);
  endtask

  task automatic test_uploads();
    stream_t s;
    send_stream(upload_stream("f", 8, "multipart/form-data"), 25);
    put_str(s, "POST /upload?X-Filename HTTP/1.1\r\nContent-Length: -7\r\n\r\n\r\n");
    send_stream(s, 0);
  endtask

  task automatic test_backpressure();
    hold_left = 1000;
    send_stream(upload_stream("p", 8, "application/octet-stream"), 0);
    wait_drained();
  endtask

  task automatic test_no_idle();
    stream_t s;
    put_str(s, "GET / HTTP/1.1\r\nHost: a\r\n\r\n");
    send_stream(s, 0);
  endtask

  initial begin
    err_count = 0;
    hold_left = 0;
    src_idle = 34;
    snk_idle = 59;
    clear_parser();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.conn_start <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.packet_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_root_page();
    test_bad_requests();
    test_uploads();
    src_idle = 59;
    snk_idle = 34;
    test_backpressure();
    src_idle = 0;
    snk_idle = 0;
    test_no_idle();
    wait_drained();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
